// ===== rtl/circular_deque_assert.svh =====
// assertion macros for the deque rtl
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CDQ_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deque check failed");

// next-cycle implication, checked outside reset
`define CDQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deque check failed");

`endif

// ===== rtl/cdq_pkg.sv =====
`default_nettype none

package cdq_pkg;

	localparam int DEPTH  = 8;
	localparam int DATA_W = 32;
	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int OCC_W  = 4;

	typedef enum logic [1:0] {
		ACT_PUSH_BACK  = 2'd0,
		ACT_POP_BACK   = 2'd1,
		ACT_PUSH_FRONT = 2'd2,
		ACT_POP_FRONT  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/circular_deque.sv =====
`default_nettype none

// Fixed-capacity double-ended queue of DEPTH signed 32-bit values held in a
// circular on-chip ram. Each input transfer carries one action (push back,
// pop back, push front, pop front) and produces exactly one result transfer
// with the popped value (zero otherwise), a status (ok, full, empty) and the
// element count after the action. A push to a full deque or a pop from an
// empty one is refused and leaves the contents alone. The block takes one
// action per cycle while input ready is high: pointers and count update at
// the input transfer, the ram read issued there returns in the next cycle,
// and a result passes through the read stage and the output register before
// it appears at the output. The read stage waits on the ram's single
// registered read port; a result stalled at the output holds back at most
// one further action in the read stage before input ready drops. The ram
// contents are not cleared at reset; only entries written by a push are ever read back.
module circular_deque
	import cdq_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         action,
	input  wire logic signed [31:0] value_in,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      value_out,
	output logic [1:0]              status,
	output logic [OCC_W-1:0]        occupancy
);

	// pointer and count state
	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;

	// read stage: action taken, ram read in flight
	logic             valid_s1;
	logic             pop_s1;
	status_t          status_s1;
	logic [CNT_W-1:0] count_s1;

	// output register
	logic                    out_valid_q;
	logic signed [31:0]      value_out_q;
	status_t                 status_q;
	logic [OCC_W-1:0]        occ_q;

	logic [DATA_W-1:0] rd_data;

	// handshake
	logic in_xfer, adv_s1;

	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign in_xfer  = in_valid && in_ready;

	// neighbors of the pointers on the ring
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	logic [PTR_W-1:0] head_up, head_dn, tail_up, tail_dn;

	assign head_up = (head_q == LAST) ? '0 : head_q + 1'b1;
	assign head_dn = (head_q == '0) ? LAST : head_q - 1'b1;
	assign tail_up = (tail_q == LAST) ? '0 : tail_q + 1'b1;
	assign tail_dn = (tail_q == '0) ? LAST : tail_q - 1'b1;

	// action decode
	logic    is_push, is_full, is_empty;
	logic    do_push_back, do_pop_back, do_push_front, do_pop_front;
	status_t act_status;

	assign is_push  = (action == ACT_PUSH_BACK) || (action == ACT_PUSH_FRONT);
	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);

	always_comb begin
		do_push_back  = 1'b0;
		do_pop_back   = 1'b0;
		do_push_front = 1'b0;
		do_pop_front  = 1'b0;
		act_status    = ST_OK;
		if (is_push && is_full) begin
			act_status = ST_FULL;
		end else if (!is_push && is_empty) begin
			act_status = ST_EMPTY;
		end else begin
			unique case (action)
				ACT_PUSH_BACK:  do_push_back  = 1'b1;
				ACT_POP_BACK:   do_pop_back   = 1'b1;
				ACT_PUSH_FRONT: do_push_front = 1'b1;
				ACT_POP_FRONT:  do_pop_front  = 1'b1;
				default:        act_status    = ST_OK;
			endcase
		end
	end

	// next pointers and count
	logic [PTR_W-1:0] head_d, tail_d;
	logic [CNT_W-1:0] count_d;

	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		count_d = count_q;
		if (do_push_back) begin
			tail_d  = tail_up;
			count_d = count_q + 1'b1;
		end
		if (do_pop_back) begin
			tail_d  = tail_dn;
			count_d = count_q - 1'b1;
		end
		if (do_push_front) begin
			head_d  = head_dn;
			count_d = count_q + 1'b1;
		end
		if (do_pop_front) begin
			head_d  = head_up;
			count_d = count_q - 1'b1;
		end
	end

	// ram access: a push writes, a pop reads, never both at once; a write
	// lands before any later read so back-to-back push/pop needs no bypass
	logic             ram_we, ram_re;
	logic [PTR_W-1:0] ram_waddr, ram_raddr;

	assign ram_we    = in_xfer && (do_push_back || do_push_front);
	assign ram_waddr = do_push_front ? head_dn : tail_q;
	assign ram_re    = in_xfer && (do_pop_back || do_pop_front);
	assign ram_raddr = do_pop_back ? tail_dn : head_q;

	cdq_ram #(
		.ENTRIES (DEPTH),
		.WIDTH   (DATA_W),
		.ADDR_W  (PTR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (value_in),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (rd_data)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				head_q  <= head_d;
				tail_q  <= tail_d;
				count_q <= count_d;
			end
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers; rd_data holds while the read stage stalls since
	// the ram only reads on an input transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pop_s1    <= do_pop_back || do_pop_front;
			status_s1 <= act_status;
			count_s1  <= count_d;
		end
		if (adv_s1) begin
			value_out_q <= pop_s1 ? rd_data : '0;
			status_q    <= status_s1;
			occ_q       <= OCC_W'(count_s1);
		end
	end

	assign out_valid = out_valid_q;
	assign value_out = value_out_q;
	assign status    = status_q;
	assign occupancy = occ_q;

`include "circular_deque_assert.svh"

	`CDQ_ASSERT(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH))
	`CDQ_ASSERT(a_ptr_meet, count_q == '0, head_q == tail_q)
	`CDQ_ASSERT(a_full_occ, out_valid_q && status_q == ST_FULL, occ_q == OCC_W'(DEPTH))
	`CDQ_ASSERT(a_empty_res, out_valid_q && status_q == ST_EMPTY,
		occ_q == '0 && value_out_q == '0)
	`CDQ_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv_s1, valid_s1)

endmodule

`default_nettype wire

// ===== rtl/cdq_ram.sv =====
`default_nettype none

// simple dual-port ram, registered read
module cdq_ram #(
	parameter int ENTRIES = 8,
	parameter int WIDTH   = 32,
	parameter int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire
